[design/otrb_pkg.sv]
// shared types and constants for the overwriting trace ring buffer
// no dependencies; imported by every module of the block
package otrb_pkg;

  // default number of trace slots
  localparam int unsigned DEF_TRACE_DEPTH = 256;

  // field widths fixed by the item format
  localparam int unsigned WORD_W = 64;
  localparam int unsigned AGE_W  = 8;
  localparam int unsigned FILL_W = 9;
  localparam int unsigned CFG_W  = 5;
  localparam int unsigned CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_KIND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SEV  = 1'd1;

  // configuration reset values
  localparam logic [4:0] MAX_KIND_RESET = 5'd19;
  localparam logic [2:0] MAX_SEV_RESET  = 3'd4;

  // request codes
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_STATUS = 2'd2;

  // visibility code that is never stored
  localparam logic [1:0] VIS_INVALID = 2'd3;

  // input item
  typedef struct packed {
    logic [1:0]        req_type;
    logic [AGE_W-1:0]  entry_age;
    logic [4:0]        event_kind;
    logic [2:0]        event_severity;
    logic [1:0]        event_visibility;
    logic [WORD_W-1:0] span_ident;
    logic [WORD_W-1:0] correlation_ident;
    logic [WORD_W-1:0] actor_ident;
    logic [WORD_W-1:0] object_ident;
    logic [WORD_W-1:0] first_argument;
    logic [WORD_W-1:0] second_argument;
    logic [WORD_W-1:0] time_now;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [WORD_W-1:0] seq_number;
    logic [WORD_W-1:0] stamp_time;
    logic [4:0]        out_kind;
    logic [2:0]        out_severity;
    logic [1:0]        out_visibility;
    logic [WORD_W-1:0] out_span;
    logic [WORD_W-1:0] out_correlation;
    logic [WORD_W-1:0] out_actor;
    logic [WORD_W-1:0] out_object;
    logic [WORD_W-1:0] out_arg_a;
    logic [WORD_W-1:0] out_arg_b;
    logic [FILL_W-1:0] fill_level;
  } out_item_t;

  // packed event codes as stored
  typedef struct packed {
    logic [1:0] vis;
    logic [2:0] sev;
    logic [4:0] kind;
  } code_t;

  // one stored trace entry
  typedef struct packed {
    logic [WORD_W-1:0] seq;
    logic [WORD_W-1:0] stamp;
    code_t             code;
    logic [WORD_W-1:0] span;
    logic [WORD_W-1:0] corr;
    logic [WORD_W-1:0] actor;
    logic [WORD_W-1:0] obj;
    logic [WORD_W-1:0] arg_a;
    logic [WORD_W-1:0] arg_b;
  } entry_t;

  // operation handed from front to back
  typedef enum logic [1:0] {
    OP_ZERO,
    OP_WRITE,
    OP_READ,
    OP_STATUS
  } op_code_t;

  // operation details, slot travels beside it
  typedef struct packed {
    op_code_t          op;
    logic [WORD_W-1:0] drop;
    logic [FILL_W-1:0] fill;
    entry_t            entry;
  } op_info_t;

endpackage

[design/otrb_front.sv]
// front end: accepts items, checks appends, keeps ring pointers and counters
// depends on otrb_pkg
module otrb_front
  import otrb_pkg::*;
#(
  parameter int unsigned TRACE_DEPTH = DEF_TRACE_DEPTH,
  parameter int unsigned SLOT_W = $clog2(TRACE_DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  in_item_t             cmd,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic [SLOT_W-1:0]    op_slot,
  output op_info_t             op_info
);

  localparam int unsigned CNT_W = $clog2(TRACE_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > AGE_W) ? CNT_W : AGE_W;
  localparam int unsigned SUM_W = ((SLOT_W > AGE_W) ? SLOT_W : AGE_W) + 1;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TRACE_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(TRACE_DEPTH);

  logic [4:0]        max_kind;
  logic [2:0]        max_sev;
  logic [SLOT_W-1:0] oldest;
  logic [SLOT_W-1:0] oldest_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [WORD_W-1:0] next_seq;
  logic [WORD_W-1:0] next_seq_next;
  logic [WORD_W-1:0] drop_total;
  logic [WORD_W-1:0] drop_total_next;

  logic              event_ok;
  logic              is_full;
  logic              age_ok;
  logic [SUM_W-1:0]  sum_raw;
  logic [SUM_W-1:0]  sum_wrap;
  logic [SUM_W-1:0]  inc_raw;
  logic [SUM_W-1:0]  inc_wrap;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_kind <= MAX_KIND_RESET;
      max_sev  <= MAX_SEV_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_KIND: max_kind <= cfg_data[4:0];
        REG_MAX_SEV:  max_sev  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // classification and slot arithmetic
  always_comb begin
    event_ok = (cmd.event_kind <= max_kind) && (cmd.event_severity <= max_sev) &&
               (cmd.event_visibility != VIS_INVALID);
    is_full  = (count == DEPTH_CNT);
    age_ok   = CMP_W'(cmd.entry_age) < CMP_W'(count);

    // oldest plus offset, offset is the fill count on append, the age on read
    if (cmd.req_type == REQ_APPEND) begin
      sum_raw = SUM_W'(oldest) + SUM_W'(count);
    end else begin
      sum_raw = SUM_W'(oldest) + SUM_W'(cmd.entry_age);
    end
    sum_wrap = (sum_raw >= DEPTH_SUM) ? (sum_raw - DEPTH_SUM) : sum_raw;

    inc_raw  = SUM_W'(oldest) + SUM_W'(1);
    inc_wrap = (inc_raw >= DEPTH_SUM) ? (inc_raw - DEPTH_SUM) : inc_raw;
  end

  // next state and operation for the queue
  always_comb begin
    oldest_next     = oldest;
    count_next      = count;
    next_seq_next   = next_seq;
    drop_total_next = drop_total;

    op_slot              = sum_wrap[SLOT_W-1:0];
    op_info.op           = OP_ZERO;
    op_info.drop         = drop_total;
    op_info.fill         = FILL_W'(count);
    op_info.entry.seq    = next_seq;
    op_info.entry.stamp  = cmd.time_now;
    op_info.entry.code   = '{vis: cmd.event_visibility, sev: cmd.event_severity,
                             kind: cmd.event_kind};
    op_info.entry.span   = cmd.span_ident;
    op_info.entry.corr   = cmd.correlation_ident;
    op_info.entry.actor  = cmd.actor_ident;
    op_info.entry.obj    = cmd.object_ident;
    op_info.entry.arg_a  = cmd.first_argument;
    op_info.entry.arg_b  = cmd.second_argument;

    case (cmd.req_type)
      REQ_APPEND: begin
        if (event_ok) begin
          op_info.op    = OP_WRITE;
          next_seq_next = next_seq + WORD_W'(1);
          if (is_full) begin
            op_slot         = oldest;
            oldest_next     = inc_wrap[SLOT_W-1:0];
            drop_total_next = drop_total + WORD_W'(1);
          end else begin
            count_next = count + CNT_W'(1);
          end
          op_info.fill = FILL_W'(count_next);
        end
      end
      REQ_READ: begin
        if (age_ok) begin
          op_info.op = OP_READ;
        end
        op_info.fill = FILL_W'(count);
      end
      REQ_STATUS: begin
        op_info.op   = OP_STATUS;
        op_info.fill = FILL_W'(count);
      end
      default: ;
    endcase
  end

  // ring pointers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest     <= '0;
      count      <= '0;
      next_seq   <= WORD_W'(1);
      drop_total <= '0;
    end else if (accept) begin
      oldest     <= oldest_next;
      count      <= count_next;
      next_seq   <= next_seq_next;
      drop_total <= drop_total_next;
    end
  end

endmodule

[design/otrb_queue.sv]
// two-entry queue between front and back
// depends on otrb_pkg only for house style
module otrb_queue
  import otrb_pkg::*;
#(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] head,
  output logic              empty,
  output logic              full
);

  logic [DATA_W-1:0] slots [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        level;
  logic              do_push;
  logic              do_pop;

  assign empty   = (level == 2'd0);
  assign full    = (level == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   level <= level + 2'd1;
        2'b01:   level <= level - 2'd1;
        default: level <= level;
      endcase
    end
  end

endmodule

[design/otrb_back.sv]
// back end: trace memory access and result formatting
// depends on otrb_pkg
module otrb_back
  import otrb_pkg::*;
#(
  parameter int unsigned TRACE_DEPTH = DEF_TRACE_DEPTH,
  parameter int unsigned SLOT_W = $clog2(TRACE_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  input  logic [SLOT_W-1:0] op_slot,
  input  op_info_t          op_info,
  output logic              done,
  output out_item_t         result
);

  entry_t   mem [TRACE_DEPTH];
  entry_t   rd_entry;
  op_info_t held;
  logic     held_valid;

  // trace memory, one write or one read per item
  always_ff @(posedge clk) begin
    if (op_valid && (op_info.op == OP_WRITE)) begin
      mem[op_slot] <= op_info.entry;
    end
    if (op_valid && (op_info.op == OP_READ)) begin
      rd_entry <= mem[op_slot];
    end
  end

  // operation held alongside the read data
  always_ff @(posedge clk) begin
    held <= op_info;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= op_valid;
    end
  end

  assign done = held_valid;

  // result formatting
  always_comb begin
    result = '0;
    case (held.op)
      OP_WRITE: begin
        result.seq_number = held.entry.seq;
        result.fill_level = held.fill;
      end
      OP_READ: begin
        result.seq_number      = rd_entry.seq;
        result.stamp_time      = rd_entry.stamp;
        result.out_kind        = rd_entry.code.kind;
        result.out_severity    = rd_entry.code.sev;
        result.out_visibility  = rd_entry.code.vis;
        result.out_span        = rd_entry.span;
        result.out_correlation = rd_entry.corr;
        result.out_actor       = rd_entry.actor;
        result.out_object      = rd_entry.obj;
        result.out_arg_a       = rd_entry.arg_a;
        result.out_arg_b       = rd_entry.arg_b;
        result.fill_level      = held.fill;
      end
      OP_STATUS: begin
        result.seq_number = held.entry.seq;
        result.out_arg_a  = held.drop;
        result.fill_level = held.fill;
      end
      default: ;
    endcase
  end

endmodule

[design/overwriting_trace_ring_buffer.sv]
// overwriting trace ring buffer, top level
// accepted items pass the queue, then the registered memory read, then the done strobe
// throughput: one item per cycle; the trace memory takes one write or one read per item
// busy rises only if the two-entry queue fills, which the always-popping back end prevents
// reset clears pointers, counters, queue and configuration; trace memory is not cleared
// depends on otrb_pkg, otrb_front, otrb_queue, otrb_back
module overwriting_trace_ring_buffer
  import otrb_pkg::*;
#(
  parameter int unsigned TRACE_DEPTH = DEF_TRACE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             cmd,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 done,
  output out_item_t            result
);

  localparam int unsigned SLOT_W = $clog2(TRACE_DEPTH);
  localparam int unsigned OP_W   = SLOT_W + $bits(op_info_t);

  logic              accept;
  logic [SLOT_W-1:0] fr_slot;
  op_info_t          fr_info;
  logic [OP_W-1:0]   q_head;
  logic              q_empty;
  logic              q_full;
  logic [SLOT_W-1:0] bk_slot;
  op_info_t          bk_info;

  assign busy   = q_full;
  assign accept = start && !busy;

  // front: accept and classify
  otrb_front #(
    .TRACE_DEPTH(TRACE_DEPTH),
    .SLOT_W(SLOT_W)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .cmd(cmd),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .op_slot(fr_slot),
    .op_info(fr_info)
  );

  // queue between front and back
  otrb_queue #(
    .DATA_W(OP_W)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(accept),
    .push_data({fr_slot, fr_info}),
    .pop(!q_empty),
    .head(q_head),
    .empty(q_empty),
    .full(q_full)
  );

  assign bk_slot = q_head[OP_W-1 -: SLOT_W];
  assign bk_info = op_info_t'(q_head[$bits(op_info_t)-1:0]);

  // back: memory and results
  otrb_back #(
    .TRACE_DEPTH(TRACE_DEPTH),
    .SLOT_W(SLOT_W)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .op_valid(!q_empty),
    .op_slot(bk_slot),
    .op_info(bk_info),
    .done(done),
    .result(result)
  );

endmodule
